### sv/shu_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
// Depends on nothing; the top level and the compression engine import it.
package shu_pkg;

   localparam int WordWidth = 32;
   localparam int BlockWords = 16;
   localparam int HashWords = 8;
   localparam int Rounds = 64;
   localparam int LenWidth = 61;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [HashWords-1:0][WordWidth-1:0] hash_type;
   typedef logic [BlockWords-1:0][WordWidth-1:0] window_type;

   // Control from the sequencer to the compression engine.
   typedef struct packed {
      logic     wr_en;
      logic [3:0] wr_addr;
      word_type wr_data;
      logic     start;
      logic     reinit;
   } eng_ctl_type;

   localparam logic [LenWidth-1:0] MaxTotalBytes = {LenWidth{1'b1}};
   localparam word_type PadWord = 32'h8000_0000;
   localparam logic [5:0] LenStartPos = 6'd56;

   localparam hash_type InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

### sv/shu_if.sv
// Valid/ready channel interfaces for message beats and digest beats.
// Depends on nothing.
interface shu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last_word;
   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface shu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_of_digest;
   logic        length_error;
   modport source (output valid, digest_word, word_index, last_of_digest, length_error,
                   input ready);
   modport sink (input valid, digest_word, word_index, last_of_digest, length_error,
                 output ready);
endinterface

### sv/sha256_message_hasher_unit.sv
// Top level of the SHA-256 message hasher: byte gathering, padding sequencer, digest output.
// Depends on shu_pkg, shu_if and shu_engine.
//
// Message beats arrive on req: a big-endian word, a byte count (0 to 4, values
// above four count as four) and a last mark. Digest beats leave on rsp: eight
// beats, H0 first, the eighth marked last_of_digest. A beat that would push
// the message length past 2^61-1 bytes is dropped and answered by one error
// beat instead.
// One item is handled at a time. A beat that does not complete a block, and is
// not the last, leaves req ready for the next beat. A beat that completes a
// 64-byte block starts a compression that holds off req (64 rounds at one per
// cycle, then the hash update). The last beat adds the padding words, one or
// two compressions, then the eight digest beats, one per cycle while rsp.ready
// is high.
// A stalled receiver holds the current digest beat and no message beat is
// taken until the digest is fully delivered. Reset is synchronous and returns
// the block to the initial hash values and an empty message at once.
module sha256_message_hasher_unit (
   input logic  clock,
   input logic  reset,
   shu_req_if.sink   req,
   shu_rsp_if.source rsp
);
   import shu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAD  = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_LEN0 = 3'd3;
   localparam logic [2:0] S_LEN1 = 3'd4;
   localparam logic [2:0] S_COMP = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;
   localparam logic [2:0] S_ERR  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          ret_ff, ret_in;
   logic [5:0]          pos_ff, pos_in;
   word_type            acc_ff, acc_in;
   logic [LenWidth-1:0] total_ff, total_in;
   logic [2:0]          idx_ff, idx_in;

   eng_ctl_type ctl;
   logic        eng_done;
   hash_type    hash;

   word_type            src_data, src_mask;
   logic [2:0]          src_cnt;
   logic [63:0]         merged;
   logic [6:0]          pos_sum;
   logic                word_done;
   logic [LenWidth:0]   total_sum;
   logic                overflow;
   logic [63:0]         bit_len;

   shu_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .done  (eng_done),
      .hash  (hash)
   );

   // Byte merge: place the new bytes after those already gathered in the word.
   always_comb begin
      if (state_ff == S_PAD) begin
         src_data = PadWord;
         src_cnt = 3'd1;
      end else begin
         src_data = req.data_word;
         src_cnt = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
      end
      src_mask = ~(32'hFFFF_FFFF >> {src_cnt, 3'b000});
      merged = {acc_ff, 32'h0} | ({src_data & src_mask, 32'h0} >> {pos_ff[1:0], 3'b000});
      pos_sum = {1'b0, pos_ff} + {4'b0000, src_cnt};
      word_done = (pos_sum[6:2] != {1'b0, pos_ff[5:2]});
      total_sum = {1'b0, total_ff} + {{(LenWidth - 2){1'b0}}, src_cnt};
      overflow = total_sum > {1'b0, MaxTotalBytes};
      bit_len = {total_ff, 3'b000};
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      pos_in = pos_ff;
      acc_in = acc_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (overflow) begin
                  state_in = S_ERR;
               end else begin
                  total_in = total_sum[LenWidth-1:0];
                  pos_in = pos_sum[5:0];
                  acc_in = word_done ? merged[31:0] : merged[63:32];
                  ctl.wr_en = word_done;
                  ctl.wr_addr = pos_ff[5:2];
                  ctl.wr_data = merged[63:32];
                  ret_in = req.last_word ? S_PAD : S_IDLE;
                  if (pos_sum[6]) begin
                     ctl.start = 1'b1;
                     state_in = S_COMP;
                  end else begin
                     state_in = req.last_word ? S_PAD : S_IDLE;
                  end
               end
            end
         end
         S_PAD: begin
            pos_in = pos_sum[5:0];
            acc_in = word_done ? merged[31:0] : merged[63:32];
            ctl.wr_en = word_done;
            ctl.wr_addr = pos_ff[5:2];
            ctl.wr_data = merged[63:32];
            ret_in = S_FILL;
            if (pos_sum[6]) begin
               ctl.start = 1'b1;
               state_in = S_COMP;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (pos_ff == LenStartPos) begin
               state_in = S_LEN0;
            end else begin
               // Flush the partial word with zero bytes and step to the next word.
               ctl.wr_en = 1'b1;
               ctl.wr_addr = pos_ff[5:2];
               ctl.wr_data = acc_ff;
               acc_in = '0;
               pos_in = {pos_ff[5:2] + 4'd1, 2'b00};
               if (pos_ff[5:2] == 4'd15) begin
                  ctl.start = 1'b1;
                  ret_in = S_FILL;
                  state_in = S_COMP;
               end
            end
         end
         S_LEN0: begin
            ctl.wr_en = 1'b1;
            ctl.wr_addr = 4'd14;
            ctl.wr_data = bit_len[63:32];
            state_in = S_LEN1;
         end
         S_LEN1: begin
            ctl.wr_en = 1'b1;
            ctl.wr_addr = 4'd15;
            ctl.wr_data = bit_len[31:0];
            ctl.start = 1'b1;
            ret_in = S_OUT;
            state_in = S_COMP;
         end
         S_COMP: begin
            if (eng_done) begin
               state_in = ret_ff;
               idx_in = 3'd0;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  // Set up for the next message.
                  ctl.reinit = 1'b1;
                  pos_in = '0;
                  acc_in = '0;
                  total_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_ERR: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         pos_ff <= '0;
         acc_ff <= '0;
         total_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         pos_ff <= pos_in;
         acc_ff <= acc_in;
         total_ff <= total_in;
         idx_ff <= idx_in;
      end
   end

   // Channel outputs.
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT) || (state_ff == S_ERR);
   assign rsp.digest_word = (state_ff == S_ERR) ? '0 : hash[idx_ff];
   assign rsp.word_index = (state_ff == S_ERR) ? 3'd0 : idx_ff;
   assign rsp.last_of_digest = (state_ff == S_ERR) || (idx_ff == 3'd7);
   assign rsp.length_error = (state_ff == S_ERR);

endmodule

### sv/shu_engine.sv
// Compression engine: block memory, message schedule window, round logic and hash words.
// Depends on shu_pkg.
module shu_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  shu_pkg::eng_ctl_type ctl,
   output logic                 done,
   output shu_pkg::hash_type    hash
);
   import shu_pkg::*;

   word_type   block_mem [BlockWords];
   word_type   rdata_ff;
   logic [3:0] rd_addr;
   logic       run_ff, run_in;
   logic       fin_ff, fin_in;
   logic [5:0] t_ff, t_in;
   hash_type   vars_ff, vars_in;
   hash_type   hash_ff, hash_in;
   window_type win_ff, win_in;
   word_type   w, t1, t2;

   // Block memory: one write port from the sequencer, one read port for rounds.
   assign rd_addr = ctl.start ? 4'd0 : (t_ff[3:0] + 4'd1);

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         block_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rdata_ff <= block_mem[rd_addr];
   end

   // Schedule word: straight from memory for the first sixteen rounds.
   always_comb begin
      if (t_ff < 6'd16) begin
         w = rdata_ff;
      end else begin
         w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      end
      t1 = vars_ff[7] + big_sigma1(vars_ff[4])
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6])) + RoundK[t_ff] + w;
      t2 = big_sigma0(vars_ff[0])
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]));
   end

   // Round sequencing and hash update.
   always_comb begin
      run_in = run_ff;
      fin_in = 1'b0;
      t_in = t_ff;
      vars_in = vars_ff;
      win_in = win_ff;
      hash_in = hash_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         t_in = 6'd0;
         vars_in = hash_ff;
      end else if (run_ff) begin
         win_in = {w, win_ff[BlockWords-1:1]};
         vars_in = {vars_ff[6], vars_ff[5], vars_ff[4], vars_ff[3] + t1,
                    vars_ff[2], vars_ff[1], vars_ff[0], t1 + t2};
         t_in = t_ff + 6'd1;
         if (t_ff == 6'(Rounds - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         for (int i = 0; i < HashWords; i++) begin
            hash_in[i] = hash_ff[i] + vars_ff[i];
         end
      end
      if (ctl.reinit) begin
         hash_in = InitHash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         t_ff <= 6'd0;
         hash_ff <= InitHash;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         t_ff <= t_in;
         hash_ff <= hash_in;
      end
      vars_ff <= vars_in;
      win_ff <= win_in;
   end

   assign done = fin_ff;
   assign hash = hash_ff;

endmodule

### sv/shu_checker.sv
// Port-level checks for the SHA-256 message hasher, bound to the top level.
// Depends on the top level's channel signals only.
module shu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] digest_word,
   input logic [2:0]  word_index,
   input logic        last_of_digest,
   input logic        length_error
);

   // An error beat stands alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && length_error |-> last_of_digest && word_index == 3'd0)
      else $error("error beat not marked as single last beat");

   // Digest beats follow each other with rising index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_digest |=>
         rsp_valid && word_index == $past(word_index) + 3'd1)
      else $error("digest beats out of order");

   // No message beat is taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   // A stalled digest beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(digest_word))
      else $error("stalled beat changed");

endmodule

bind sha256_message_hasher_unit shu_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .digest_word    (rsp.digest_word),
   .word_index     (rsp.word_index),
   .last_of_digest (rsp.last_of_digest),
   .length_error   (rsp.length_error)
);
